/* design/mtbd_pkg.sv */
// Shared types, constants and functions for the MT19937 bounded draw core.
package mtbd_pkg;

	localparam int STATE_WORDS  = 624;
	localparam int SHIFT_OFFSET = 397;
	localparam int WORD_W       = 32;
	localparam int ADDR_W       = $clog2(STATE_WORDS);
	localparam int IDX_W        = $clog2(STATE_WORDS + 1);

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [IDX_W-1:0]  idx_t;

	localparam word_t MATRIX_A     = 32'h9908_b0df;
	localparam word_t TEMPER_B     = 32'h9d2c_5680;
	localparam word_t TEMPER_C     = 32'hefc6_0000;
	localparam word_t INIT_MULT    = 32'd1812433253;
	localparam word_t DEFAULT_SEED = 32'hfedc_ba09;
	localparam word_t UPPER_BIT    = 32'h8000_0000;
	localparam word_t LOWER_BITS   = 32'h7fff_ffff;

	localparam addr_t LAST_ADDR = ADDR_W'(STATE_WORDS - 1);
	localparam addr_t FAR_STEP  = ADDR_W'(SHIFT_OFFSET);
	localparam addr_t FAR_WRAP  = ADDR_W'(STATE_WORDS - SHIFT_OFFSET);
	localparam idx_t  IDX_FULL  = IDX_W'(STATE_WORDS);

	function automatic word_t temper(input word_t y);
		word_t t1;
		word_t t2;
		word_t t3;
		t1 = y ^ (y >> 11);
		t2 = t1 ^ ((t1 << 7) & TEMPER_B);
		t3 = t2 ^ ((t2 << 15) & TEMPER_C);
		return t3 ^ (t3 >> 18);
	endfunction

	function automatic word_t cover_mask(input word_t lim);
		word_t m;
		m = lim;
		m = m | (m >> 1);
		m = m | (m >> 2);
		m = m | (m >> 4);
		m = m | (m >> 8);
		m = m | (m >> 16);
		return m;
	endfunction

	function automatic word_t twist_word(input word_t cur, input word_t nxt, input word_t far);
		word_t y;
		y = (cur & UPPER_BIT) | (nxt & LOWER_BITS);
		return far ^ (y >> 1) ^ (nxt[0] ? MATRIX_A : '0);
	endfunction

endpackage

/* design/mtbd_limit_if.sv */
// Request channel carrying the draw limit.
interface mtbd_limit_if;
	logic                 valid;
	logic                 ready;
	logic [31:0] limit;

	modport source (output valid, output limit, input ready);
	modport sink   (input valid, input limit, output ready);
endinterface

/* design/mtbd_value_if.sv */
// Result channel carrying the drawn value.
interface mtbd_value_if;
	logic                 valid;
	logic                 ready;
	logic [31:0] value;

	modport source (output valid, output value, input ready);
	modport sink   (input valid, input value, output ready);
endinterface

/* design/mtbd_ram.sv */
// Generic RAM with one write port and two registered read ports.
module mtbd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 624
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	output logic [WIDTH-1:0]         rdata_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_b
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end
endmodule

/* design/mersenne_twister_bounded_draw_core.sv */
// MT19937 generator returning one tempered draw at most a requested limit per request.
// Each request reads state words in turn and checks them; a rejected draw reads the next word.
// After every 624th word the state is twisted before the next draw.
// One request in flight; a request passes the idle, read and check states, and the result register
// frees the request side at once unless the previous result is still unaccepted (then S_HOLD).
// Reset and every seed write run the seed fill and a twist; no request is taken meanwhile.
// Reset loads the seed 0xFEDCBA09.
module mersenne_twister_bounded_draw_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  mtbd_pkg::word_t      cfg_wdata,
	mtbd_limit_if.sink           req,
	mtbd_value_if.source         rsp
);
	import mtbd_pkg::*;

	typedef enum logic [3:0] {
		S_INIT0,
		S_INIT_MUL,
		S_INIT_ADD,
		S_TW_PRE,
		S_TW_LD,
		S_TW_RD,
		S_TW_WR,
		S_IDLE,
		S_DRAW_RD,
		S_DRAW_CHK,
		S_HOLD
	} state_t;

	state_t state_q;
	word_t  seed_q;
	word_t  prev_q;
	word_t  prod_q;
	word_t  cur_q;
	word_t  lim_q;
	word_t  mask_q;
	word_t  res_q;
	word_t  value_q;
	logic   out_valid_q;
	logic   busy_q;
	addr_t  cnt_q;
	idx_t   idx_q;

	logic   ram_we;
	addr_t  ram_waddr;
	word_t  ram_wdata;
	addr_t  raddr_a;
	addr_t  raddr_b;
	word_t  rdata_a;
	word_t  rdata_b;

	word_t  mix;
	word_t  init_word;
	word_t  masked;
	addr_t  nxt_addr;
	addr_t  far_addr;
	logic   out_load;

	mtbd_ram #(
		.WIDTH(WORD_W),
		.DEPTH(STATE_WORDS)
	) u_state_ram (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (ram_waddr),
		.wdata   (ram_wdata),
		.raddr_a (raddr_a),
		.rdata_a (rdata_a),
		.raddr_b (raddr_b),
		.rdata_b (rdata_b)
	);

	assign mix       = prev_q ^ (prev_q >> 30);
	assign init_word = prod_q + WORD_W'(cnt_q);
	assign masked    = temper(rdata_a) & mask_q;
	assign nxt_addr  = (cnt_q == LAST_ADDR) ? '0 : cnt_q + 1'b1;
	assign far_addr  = (cnt_q < FAR_WRAP) ? cnt_q + FAR_STEP : cnt_q - FAR_WRAP;
	assign out_load  = !cfg_we && (((state_q == S_DRAW_CHK) && (masked <= lim_q)
		&& (!out_valid_q || rsp.ready)) || ((state_q == S_HOLD) && rsp.ready));

	assign req.ready = (state_q == S_IDLE);
	assign rsp.valid = out_valid_q;
	assign rsp.value = value_q;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = cnt_q;
		ram_wdata = twist_word(cur_q, rdata_a, rdata_b);
		raddr_a   = '0;
		raddr_b   = '0;
		unique case (state_q) inside
			S_INIT0: begin
				ram_we    = 1'b1;
				ram_waddr = '0;
				ram_wdata = seed_q;
			end
			S_INIT_ADD: begin
				ram_we    = 1'b1;
				ram_wdata = init_word;
			end
			S_TW_LD, S_TW_RD: begin
				raddr_a = nxt_addr;
				raddr_b = far_addr;
			end
			S_TW_WR: begin
				ram_we = 1'b1;
			end
			S_DRAW_RD: begin
				raddr_a = idx_q[ADDR_W-1:0];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT0;
			seed_q      <= DEFAULT_SEED;
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
			idx_q       <= IDX_FULL;
			cnt_q       <= '0;
		end else begin
			if (rsp.ready && !out_load) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				seed_q  <= cfg_wdata;
				busy_q  <= 1'b0;
				state_q <= S_INIT0;
			end else begin
				unique case (state_q)
					S_INIT0: begin
						prev_q  <= seed_q;
						cnt_q   <= addr_t'(1);
						state_q <= S_INIT_MUL;
					end
					S_INIT_MUL: begin
						prod_q  <= INIT_MULT * mix;
						state_q <= S_INIT_ADD;
					end
					S_INIT_ADD: begin
						prev_q <= init_word;
						if (cnt_q == LAST_ADDR) begin
							state_q <= S_TW_PRE;
						end else begin
							cnt_q   <= cnt_q + 1'b1;
							state_q <= S_INIT_MUL;
						end
					end
					S_TW_PRE: begin
						cnt_q   <= '0;
						state_q <= S_TW_LD;
					end
					S_TW_LD: begin
						cur_q   <= rdata_a;
						state_q <= S_TW_WR;
					end
					S_TW_RD: begin
						state_q <= S_TW_WR;
					end
					S_TW_WR: begin
						cur_q <= rdata_a;
						if (cnt_q == LAST_ADDR) begin
							cnt_q   <= '0;
							idx_q   <= '0;
							state_q <= busy_q ? S_DRAW_RD : S_IDLE;
						end else begin
							cnt_q   <= cnt_q + 1'b1;
							state_q <= S_TW_RD;
						end
					end
					S_IDLE: begin
						if (req.valid) begin
							lim_q   <= req.limit;
							mask_q  <= cover_mask(req.limit);
							busy_q  <= 1'b1;
							state_q <= S_DRAW_RD;
						end
					end
					S_DRAW_RD: begin
						if (idx_q == IDX_FULL) begin
							state_q <= S_TW_PRE;
						end else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= S_DRAW_CHK;
						end
					end
					S_DRAW_CHK: begin
						if (masked <= lim_q) begin
							if (!out_valid_q || rsp.ready) begin
								value_q     <= masked;
								out_valid_q <= 1'b1;
								busy_q      <= 1'b0;
								state_q     <= S_IDLE;
							end else begin
								res_q   <= masked;
								state_q <= S_HOLD;
							end
						end else begin
							state_q <= S_DRAW_RD;
						end
					end
					S_HOLD: begin
						if (rsp.ready) begin
							value_q     <= res_q;
							out_valid_q <= 1'b1;
							busy_q      <= 1'b0;
							state_q     <= S_IDLE;
						end
					end
					default: begin
						state_q <= S_IDLE;
					end
				endcase
			end
		end
	end

	a_ready_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req.ready |-> !busy_q)
		else $error("request taken while a draw is in progress");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= IDX_FULL)
		else $error("word index beyond state size");

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_HOLD) |-> rsp.valid)
		else $error("result held while output register is empty");

endmodule
